FILE: rtl/swls_pkg.sv
// shared constants and command/status types for the sliding window level stats block
// no dependencies
package swls_pkg;

   localparam int LEVEL_W      = 10;
   localparam int LEVELS       = 1 << LEVEL_W;
   localparam int WSUM_W       = 20;
   localparam int TSUM_W       = 17;
   localparam int DEF_WINDOW   = 1024;
   localparam int DEF_TOP      = 102;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 48;

   // controller to datapath commands
   typedef struct packed {
      logic accept;      // latch incoming sample
      logic clr_step;    // write one histogram bin of the clearing pass
      logic ring_rw;     // read oldest ring entry, write new sample
      logic hist_rd_old; // read bin of the replaced sample, update total
      logic hist_wr_dec; // write back decremented bin
      logic hist_rd_new; // read bin of the new sample
      logic hist_wr_inc; // write back incremented bin
      logic walk_start;  // arm the histogram walk
      logic walk_step;   // read one bin, highest level first
      logic load_out;    // move results into the output register
   } swls_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clr_last;
      logic walk_last;
      logic out_busy;
   } swls_sts_type;

endpackage

FILE: rtl/sliding_window_level_stats_top.sv
// after an accepted beat: ring update, histogram update, walk of all 1024 bins, then rsp_tvalid
// one beat in flight; the next is taken after the walk and the result load, which waits on rsp_tready
// after reset a clearing pass writes all 1024 histogram bins; req_tready stays low meanwhile
// reset is synchronous and active high; ring contents need no clearing (a wrap flag masks them)
// top level of the sliding window level stats block
// depends on swls_pkg, swls_ctrl, swls_dp
module sliding_window_level_stats_top #(
   parameter int WINDOW = swls_pkg::DEF_WINDOW,
   parameter int TOP    = swls_pkg::DEF_TOP
) (
   input  logic                              clock,
   input  logic                              reset,
   // sample beat
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [swls_pkg::REQ_DATA_W-1:0]   req_tdata,  // [9:0] sample
   // result beat
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [swls_pkg::RSP_DATA_W-1:0]   rsp_tdata   // [19:0] window_sum, [36:20] top_sum,
                                                         // [46:37] window_peak, [47] zero
);
   import swls_pkg::*;

   swls_cmd_type       cmd;
   swls_sts_type       sts;
   logic [WSUM_W-1:0]  window_sum;
   logic [TSUM_W-1:0]  top_sum;
   logic [LEVEL_W-1:0] window_peak;

   // sequencer: clear, update ring and histogram, walk, hand off
   swls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // storage and arithmetic
   swls_dp #(
      .WINDOW (WINDOW),
      .TOP    (TOP)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .sample      (req_tdata[LEVEL_W-1:0]),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .window_sum  (window_sum),
      .top_sum     (top_sum),
      .window_peak (window_peak)
   );

   // pack result fields, lowest first, pad to whole bytes
   assign rsp_tdata = {{(RSP_DATA_W - WSUM_W - TSUM_W - LEVEL_W){1'b0}},
                       window_peak, top_sum, window_sum};

endmodule

FILE: rtl/swls_ctrl.sv
// controller state machine: sequences ring and histogram update and the histogram walk
// depends on swls_pkg
module swls_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  swls_pkg::swls_sts_type sts,
   output swls_pkg::swls_cmd_type cmd
);
   import swls_pkg::*;

   localparam logic [3:0] ST_CLR   = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_RING  = 4'd2;
   localparam logic [3:0] ST_OLD   = 4'd3;
   localparam logic [3:0] ST_DEC   = 4'd4;
   localparam logic [3:0] ST_RDS   = 4'd5;
   localparam logic [3:0] ST_INC   = 4'd6;
   localparam logic [3:0] ST_WALK  = 4'd7;
   localparam logic [3:0] ST_DRAIN = 4'd8;
   localparam logic [3:0] ST_DONE  = 4'd9;

   logic [3:0] state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_RING;
            end
         end
         ST_RING: begin
            cmd.ring_rw = 1'b1;
            state_in    = ST_OLD;
         end
         ST_OLD: begin
            cmd.hist_rd_old = 1'b1;
            state_in        = ST_DEC;
         end
         ST_DEC: begin
            cmd.hist_wr_dec = 1'b1;
            state_in        = ST_RDS;
         end
         ST_RDS: begin
            cmd.hist_rd_new = 1'b1;
            state_in        = ST_INC;
         end
         ST_INC: begin
            cmd.hist_wr_inc = 1'b1;
            cmd.walk_start  = 1'b1;
            state_in        = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (sts.walk_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!sts.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLR;
      else       state_ff <= state_in;
   end

endmodule

FILE: rtl/swls_dp.sv
// datapath: sample ring, level histogram, running total, walk accumulators, output register
// depends on swls_pkg
module swls_dp #(
   parameter int WINDOW = swls_pkg::DEF_WINDOW,
   parameter int TOP    = swls_pkg::DEF_TOP
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [swls_pkg::LEVEL_W-1:0]  sample,
   input  swls_pkg::swls_cmd_type        cmd,
   output swls_pkg::swls_sts_type        sts,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [swls_pkg::WSUM_W-1:0]   window_sum,
   output logic [swls_pkg::TSUM_W-1:0]   top_sum,
   output logic [swls_pkg::LEVEL_W-1:0]  window_peak
);
   import swls_pkg::*;

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int ACC_W  = LEVEL_W + CNT_W;
   localparam int NEED0  = (TOP > WINDOW) ? WINDOW : TOP;

   // sample ring
   logic [LEVEL_W-1:0] ring_mem [WINDOW];
   logic [LEVEL_W-1:0] ring_rd_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic               wrapped_ff, old_valid_ff;
   logic [LEVEL_W-1:0] sample_ff, old_ff, old_w;

   // level histogram
   logic [CNT_W-1:0]   hist_mem [LEVELS];
   logic [CNT_W-1:0]   hist_rd_ff;
   logic [LEVEL_W-1:0] hist_raddr, hist_waddr;
   logic [CNT_W-1:0]   hist_wdata;
   logic               hist_we;
   logic [LEVEL_W-1:0] clr_ff;

   logic [ACC_W-1:0]   total_ff;

   // walk
   logic [LEVEL_W-1:0] lvl_ff, proc_lvl_ff, peak_ff;
   logic               proc_valid_ff, found_ff;
   logic [CNT_W-1:0]   need_ff, take_w;
   logic [ACC_W-1:0]   tsum_ff;

   // output register
   logic               rsp_valid_ff;
   logic [WSUM_W-1:0]  wsum_ff;
   logic [TSUM_W-1:0]  tsum_out_ff;
   logic [LEVEL_W-1:0] peak_out_ff;

   assign old_w = old_valid_ff ? ring_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.ring_rw) begin
         ring_rd_ff        <= ring_mem[slot_ff];
         ring_mem[slot_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         wrapped_ff   <= 1'b0;
         old_valid_ff <= 1'b0;
      end else if (cmd.ring_rw) begin
         old_valid_ff <= wrapped_ff;
         if (slot_ff == SLOT_W'(WINDOW - 1)) begin
            slot_ff    <= '0;
            wrapped_ff <= 1'b1;
         end else begin
            slot_ff <= slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept)      sample_ff <= sample;
      if (cmd.hist_rd_old) old_ff    <= old_w;
   end

   always_comb begin
      hist_raddr = lvl_ff;
      if (cmd.hist_rd_old)      hist_raddr = old_w;
      else if (cmd.hist_rd_new) hist_raddr = sample_ff;
      hist_we    = cmd.clr_step | cmd.hist_wr_dec | cmd.hist_wr_inc;
      hist_waddr = clr_ff;
      hist_wdata = (clr_ff == '0) ? CNT_W'(WINDOW) : '0;
      if (cmd.hist_wr_dec) begin
         hist_waddr = old_ff;
         hist_wdata = (hist_rd_ff == '0) ? '0 : hist_rd_ff - 1'b1;
      end else if (cmd.hist_wr_inc) begin
         hist_waddr = sample_ff;
         hist_wdata = hist_rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
      hist_rd_ff <= hist_mem[hist_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset)              clr_ff <= '0;
      else if (cmd.clr_step)  clr_ff <= clr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset)                total_ff <= '0;
      else if (cmd.hist_rd_old) total_ff <= total_ff - ACC_W'(old_w) + ACC_W'(sample_ff);
   end

   // walk from the top level down, one bin read per cycle, each bin processed in the cycle after its read
   assign take_w = (hist_rd_ff < need_ff) ? hist_rd_ff : need_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         proc_valid_ff <= 1'b0;
      end else begin
         proc_valid_ff <= cmd.walk_step;
      end
      if (cmd.walk_start) begin
         lvl_ff   <= '1;
         need_ff  <= CNT_W'(NEED0);
         tsum_ff  <= '0;
         peak_ff  <= '0;
         found_ff <= 1'b0;
      end else begin
         if (cmd.walk_step) begin
            lvl_ff      <= lvl_ff - 1'b1;
            proc_lvl_ff <= lvl_ff;
         end
         if (proc_valid_ff && hist_rd_ff != '0) begin
            if (!found_ff) begin
               peak_ff  <= proc_lvl_ff;
               found_ff <= 1'b1;
            end
            tsum_ff <= tsum_ff + ACC_W'(take_w) * ACC_W'(proc_lvl_ff);
            need_ff <= need_ff - take_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         wsum_ff     <= (total_ff > ACC_W'({WSUM_W{1'b1}})) ? '1 : WSUM_W'(total_ff);
         tsum_out_ff <= (tsum_ff > ACC_W'({TSUM_W{1'b1}})) ? '1 : TSUM_W'(tsum_ff);
         peak_out_ff <= peak_ff;
      end
   end

   assign sts.clr_last  = (clr_ff == '1);
   assign sts.walk_last = (lvl_ff == '0);
   assign sts.out_busy  = rsp_valid_ff;

   assign rsp_valid   = rsp_valid_ff;
   assign window_sum  = wsum_ff;
   assign top_sum     = tsum_out_ff;
   assign window_peak = peak_out_ff;

endmodule

FILE: rtl/swls_checker.sv
// port-level checks for the sliding window level stats block, bound to the top level
// depends on swls_pkg, sliding_window_level_stats_top
module swls_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [swls_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import swls_pkg::*;

   // result beat holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped while stalled");

   // one sample in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second sample taken during processing");

   // top sum always covers the peak
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[36:20] >= 17'(rsp_tdata[46:37]))
      else $error("top sum below peak");

   // nothing shown right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("handshake active after reset");

endmodule

bind sliding_window_level_stats_top swls_checker u_swls_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: test/testbench.sv
// self-checking testbench for the sliding window level stats block
// depends on swls_pkg and sliding_window_level_stats_top; predicts window sum, top sum and peak
module testbench;
   import swls_pkg::*;

   localparam int WINDOW    = DEF_WINDOW;
   localparam int TOP       = DEF_TOP;
   localparam int N_RANDOM  = 268;
   localparam int CYC_LIMIT = 4_000_000;

   typedef struct packed {
      logic [LEVEL_W-1:0] peak;
      logic [TSUM_W-1:0]  top_sum;
      logic [WSUM_W-1:0]  win_sum;
   } level_stats_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   sliding_window_level_stats_top #(.WINDOW(WINDOW), .TOP(TOP)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [9:0] sample, upper bits ignored
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // [19:0] window_sum, [36:20] top_sum, [46:37] window_peak
   );

   always #4 clock = ~clock;

   // predictor state: ring of levels, oldest slot pointer, sum and level histogram
   logic [LEVEL_W-1:0] level_ring [WINDOW];
   int unsigned        oldest_slot;
   int unsigned        ring_total;
   int unsigned        level_count [LEVELS];

   logic [REQ_DATA_W-1:0] pending_samples [$];
   level_stats_type       expected_stats  [$];

   int  fail_count    = 0;
   int  beats_in      = 0;
   int  beats_out     = 0;
   int  cycle_count   = 0;
   bit  stim_done     = 1'b0;
   bit  quiet_phase   = 1'b0;  // no idling on either side near the end
   int  send_gap      = 0;
   int  recv_gap      = 0;

   // push one sample into the window and return the stats it should produce
   function automatic level_stats_type window_stats_after(logic [REQ_DATA_W-1:0] raw);
      logic [LEVEL_W-1:0] lvl_new;
      logic [LEVEL_W-1:0] lvl_old;
      int unsigned        still_needed;
      int unsigned        top_acc;
      int unsigned        took;
      int unsigned        highest;
      bit                 seen;
      level_stats_type    r;
      lvl_new = raw[LEVEL_W-1:0];
      lvl_old = level_ring[oldest_slot];
      ring_total = ring_total - lvl_old + lvl_new;
      if (level_count[lvl_old] > 0) level_count[lvl_old]--;
      level_count[lvl_new]++;
      level_ring[oldest_slot] = lvl_new;
      oldest_slot = (oldest_slot + 1) % WINDOW;
      still_needed = (TOP > WINDOW) ? WINDOW : TOP;
      top_acc = 0;
      highest = 0;
      seen = 1'b0;
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (level_count[l] != 0) begin
            if (!seen) begin
               highest = l;
               seen = 1'b1;
            end
            took = (level_count[l] < still_needed) ? level_count[l] : still_needed;
            top_acc += took * l;
            still_needed -= took;
         end
      end
      // saturate to field widths
      r.win_sum = (ring_total > (2**WSUM_W - 1)) ? '1 : ring_total[WSUM_W-1:0];
      r.top_sum = (top_acc > (2**TSUM_W - 1)) ? '1 : top_acc[TSUM_W-1:0];
      r.peak    = highest[LEVEL_W-1:0];
      return r;
   endfunction

   // random stray upper bits on top of a level
   function automatic logic [REQ_DATA_W-1:0] with_stray(int unsigned lvl);
      logic [REQ_DATA_W-1:0] v;
      v = REQ_DATA_W'($urandom);
      v[LEVEL_W-1:0] = lvl[LEVEL_W-1:0];
      return v;
   endfunction

   // sender: keeps tvalid up while a beat waits, idles in random bursts
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            beats_in <= beats_in + 1;
            expected_stats.push_back(window_stats_after(req_tdata));
            void'(pending_samples.pop_front());
         end
         if (req_tvalid && !req_tready) begin
            // hold the beat
         end else if (send_gap > 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            if (!quiet_phase && $urandom_range(0, 3) == 0) begin
               send_gap   <= $urandom_range(1, 10);
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_samples[0];
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stall bursts on tready, checks every result beat
   always @(posedge clock) begin
      level_stats_type got;
      level_stats_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[WSUM_W+TSUM_W+LEVEL_W-1:0];
            beats_out <= beats_out + 1;
            if (expected_stats.size() == 0) begin
               $error("result beat with no expectation: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_stats.pop_front();
               if (got.win_sum !== want.win_sum) begin
                  $error("window_sum expected %0d got %0d", want.win_sum, got.win_sum);
                  fail_count++;
               end
               if (got.top_sum !== want.top_sum) begin
                  $error("top_sum expected %0d got %0d", want.top_sum, got.top_sum);
                  fail_count++;
               end
               if (got.peak !== want.peak) begin
                  $error("window_peak expected %0d got %0d", want.peak, got.peak);
                  fail_count++;
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap   <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            recv_gap   <= $urandom_range(1, 10);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYC_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_stats.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned burst_level;
      for (int i = 0; i < WINDOW; i++) level_ring[i] = '0;
      for (int l = 0; l < LEVELS; l++) level_count[l] = 0;
      level_count[0] = WINDOW;
      oldest_slot = 0;
      ring_total  = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: zero window at start, extremes, stray upper bits, alternating bit patterns
      pending_samples.push_back(16'd0);
      pending_samples.push_back(16'd1023);
      pending_samples.push_back(16'd1);
      pending_samples.push_back(16'hFFFF);       // masks to 1023
      pending_samples.push_back(16'hFC00);       // masks to 0
      pending_samples.push_back(16'd512);
      pending_samples.push_back(16'h02AA);
      pending_samples.push_back(16'h0155);
      pending_samples.push_back(16'hAAAA);
      pending_samples.push_back(16'h5555);
      for (int i = 0; i < 8; i++) pending_samples.push_back(16'd1023);
      for (int i = 0; i < 4; i++) pending_samples.push_back(16'd0);

      // random: mostly level runs and loud or quiet samples so the top set and peak move, some uniform noise
      while (pending_samples.size() < 22 + N_RANDOM) begin
         case ($urandom_range(0, 3))
            0: pending_samples.push_back(with_stray($urandom_range(0, 1023)));
            1: begin
               burst_level = $urandom_range(0, 1023);
               repeat ($urandom_range(1, 12))
                  pending_samples.push_back(with_stray(burst_level));
            end
            2: pending_samples.push_back(with_stray($urandom_range(900, 1023)));
            default: pending_samples.push_back(with_stray($urandom_range(0, 40)));
         endcase
      end

      // last stretch without idling
      wait (pending_samples.size() < 30);
      quiet_phase = 1'b1;
      wait (pending_samples.size() == 0 && !req_tvalid);
      wait (expected_stats.size() == 0);
      repeat (1100) @(posedge clock);

      $display("fed %0d samples (directed extremes, level runs, noise, stray upper bits)",
               beats_in);
      $display("checked %0d result beats over %0d cycles", beats_out, cycle_count);
      if (fail_count == 0 && expected_stats.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/swls_pkg.sv
rtl/swls_ctrl.sv
rtl/swls_dp.sv
rtl/sliding_window_level_stats_top.sv
rtl/swls_checker.sv
test/testbench.sv
